### rtl/core/trapezoid_motion_profile_eval_defines.svh
// Assertion macros shared by the trapezoid profile RTL.
// Each macro expects signals named clock and reset in the enclosing module.
`ifndef TRAPEZOID_MOTION_PROFILE_EVAL_DEFINES_SVH
`define TRAPEZOID_MOTION_PROFILE_EVAL_DEFINES_SVH

// Condition that must hold at every clock edge out of reset.
`define TMPE_ASSERT_ALWAYS(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("trapezoid profile check failed");

// Consequence that must hold in the same cycle as the antecedent.
`define TMPE_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("trapezoid profile check failed");

// Consequence that must hold in the cycle after the antecedent.
`define TMPE_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("trapezoid profile check failed");

`endif

### rtl/core/tmpe_pkg.sv
// Package for the trapezoid profile evaluator: word types, codes, stage counts
// and the per-stage square root, divide and saturation functions. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tmpe_pkg;

   localparam int unsigned FR_STAGES   = 4;
   localparam int unsigned SQ_STAGES   = 32;
   localparam int unsigned MD_STAGES   = 3;
   localparam int unsigned DIV_STAGES  = 64;
   localparam int unsigned EV_STAGES   = 12;
   localparam int unsigned PIPE_STAGES = FR_STAGES + SQ_STAGES + MD_STAGES
                                         + DIV_STAGES + EV_STAGES;

   localparam logic [1:0] SEG_ACCEL   = 2'd0;
   localparam logic [1:0] SEG_CRUISE  = 2'd1;
   localparam logic [1:0] SEG_DECEL   = 2'd2;
   localparam logic [1:0] SEG_OUTSIDE = 2'd3;

   // Register select is address bit 2.
   localparam logic REG_MAX_VELOCITY = 1'b0;
   localparam logic REG_MAX_ACCEL    = 1'b1;
   localparam logic [31:0] CFG_RESET_VALUE = 32'h0001_0000;

   typedef struct packed {
      logic signed [31:0] start_pos;
      logic signed [31:0] end_pos;
      logic signed [31:0] sample_time;
   } req_word_type;

   typedef struct packed {
      logic signed [31:0] position;
      logic signed [31:0] velocity;
      logic signed [31:0] accel;
      logic [1:0]         segment;
   } rsp_word_type;

   typedef struct packed {
      logic [31:0] q0;
      logic [31:0] q1;
      logic [31:0] t;
      logic        neg;
      logic        nz;
      logic [32:0] mag;
   } item_type;

   typedef struct packed {
      item_type    item;
      logic        limit;
      logic [63:0] xr;
      logic [33:0] rem;
      logic [31:0] root;
   } sq_type;

   typedef struct packed {
      logic [32:0] rem;
      logic [63:0] nq;
   } dstep_type;

   // One digit of the restoring square root: two radicand bits in, one root bit out.
   function automatic sq_type sqrt_step(input sq_type s);
      sq_type      r;
      logic [35:0] rt;
      logic [35:0] trial;
      r     = s;
      rt    = {s.rem, s.xr[63:62]};
      trial = {2'b00, s.root, 2'b01};
      r.xr  = {s.xr[61:0], 2'b00};
      if (rt >= trial) begin
         r.rem  = 34'(rt - trial);
         r.root = {s.root[30:0], 1'b1};
      end else begin
         r.rem  = rt[33:0];
         r.root = {s.root[30:0], 1'b0};
      end
      return r;
   endfunction

   // One quotient bit of restoring division; the dividend shifts out at the top
   // while quotient bits shift in at the bottom.
   function automatic dstep_type div_step(input dstep_type d, input logic [32:0] dvs);
      dstep_type   r;
      logic [33:0] trial;
      trial = {d.rem, d.nq[63]};
      if (trial >= {1'b0, dvs}) begin
         r.rem = 33'(trial - {1'b0, dvs});
         r.nq  = {d.nq[62:0], 1'b1};
      end else begin
         r.rem = trial[32:0];
         r.nq  = {d.nq[62:0], 1'b0};
      end
      return r;
   endfunction

   function automatic logic [31:0] sat32(input logic signed [65:0] v);
      logic [31:0] r;
      if (v > 66'sd2147483647) begin
         r = 32'h7fff_ffff;
      end else if (v < -66'sd2147483648) begin
         r = 32'h8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

### rtl/core/trapezoid_motion_profile_eval.sv
// Top level of the trapezoid profile evaluator: the full evaluation pipeline,
// output buffer and configuration registers. Depends on tmpe_pkg and the defines header.
//
// Usage. A request word carries start position, end position and sample time, all
// signed Q16.16. For every request the block returns exactly one response word with
// position, velocity, acceleration and segment code of the profile at that time.
// The request channel is accepted on a clock edge where req_valid is high and
// req_stall is low; the response channel works the same way with rsp_stall.
// Throughput is one word per cycle while rsp_stall stays low. The pipeline holds
// the 32 root-digit stages and the 64 quotient-bit stages of the three dividers
// (tau, end of cruise and the cruise offset constant).
// When the receiver stalls, the response register holds its word and one more word
// lands in a skid register; only then does req_stall rise and the whole pipeline
// freeze, so no word is lost or repeated.
// Reset is synchronous and active high: it empties the pipeline and buffers and
// loads both max_velocity and max_accel with 1.0. The APB-style port writes the
// registers and should only be used while no request is in flight.
`timescale 1ns / 1ps
`default_nettype none
`include "trapezoid_motion_profile_eval_defines.svh"

module trapezoid_motion_profile_eval
   import tmpe_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire req_word_type req_word,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output rsp_word_type      rsp_word,
   input  wire logic         psel,
   input  wire logic         penable,
   input  wire logic         pwrite,
   input  wire logic [2:0]   paddr,
   input  wire logic [31:0]  pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   // Front stages: distance, magnitude, the two products and the velocity limit test.
   typedef struct packed {
      item_type    item;
      logic [32:0] d;
      logic [63:0] pda;
      logic [63:0] vv2;
      logic        limit;
   } fr_type;

   // Stages between root and dividers: peak velocity, its square, the offset numerator.
   typedef struct packed {
      item_type    item;
      logic [31:0] vpk;
      logic [63:0] vsq;
      logic [63:0] num;
   } md_type;

   typedef struct packed {
      item_type    item;
      logic [31:0] vpk;
      dstep_type   tau;
      dstep_type   tc;
      dstep_type   cof;
   } dv_type;

   // Evaluation stages; each stage fills in a few more fields.
   typedef struct packed {
      item_type    item;
      logic [31:0] vpk;
      logic [47:0] tau;
      logic [48:0] tc;
      logic [62:0] cof;
      logic [49:0] total;
      logic [49:0] ut;
      logic        tneg;
      logic        le_tau;
      logic        le_tc;
      logic        le_tot;
      logic [49:0] u;
      logic [1:0]  seg;
      logic [49:0] w;
      logic [31:0] m;
      logic [63:0] plo;
      logic [31:0] phi;
      logic [63:0] prod;
      logic [47:0] vv;
      logic [63:0] pa;
      logic [31:0] pb;
      logic [31:0] pc;
      logic [63:0] off1;
      logic [31:0] pbc;
      logic [63:0] prod2;
      logic [63:0] off;
      logic [63:0] term;
      logic [31:0] base;
      logic [31:0] vel;
      logic [31:0] acc;
      logic [31:0] pos;
   } ev_type;

   logic [31:0] max_velocity_ff;
   logic [31:0] max_accel_ff;
   logic [31:0] vlim;
   logic [31:0] alim;

   logic                   en;
   logic [PIPE_STAGES-1:0] vld_ff;

   fr_type f_ff [FR_STAGES];
   fr_type f_in [FR_STAGES];
   sq_type sq_ff [SQ_STAGES];
   sq_type sq_in [SQ_STAGES];
   md_type m_ff [MD_STAGES];
   md_type m_in [MD_STAGES];
   dv_type dv_ff [DIV_STAGES];
   dv_type dv_in [DIV_STAGES];
   ev_type e_ff [EV_STAGES];
   ev_type e_in [EV_STAGES];

   rsp_word_type pipe_word;
   logic         rsp_v_ff;
   rsp_word_type rsp_d_ff;
   logic         skid_v_ff;
   rsp_word_type skid_d_ff;
   logic         pipe_push;
   logic         rsp_pop;

   // A register value of zero behaves as one raw count.
   assign vlim = (max_velocity_ff == 32'd0) ? 32'd1 : max_velocity_ff;
   assign alim = (max_accel_ff == 32'd0) ? 32'd1 : max_accel_ff;

   // Configuration registers.
   assign pready = 1'b1;
   assign prdata = (paddr[2] == REG_MAX_ACCEL) ? max_accel_ff : max_velocity_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_velocity_ff <= CFG_RESET_VALUE;
         max_accel_ff    <= CFG_RESET_VALUE;
      end else if (psel && penable && pwrite && pready) begin
         if (paddr[2] == REG_MAX_ACCEL) begin
            max_accel_ff <= pwdata;
         end else begin
            max_velocity_ff <= pwdata;
         end
      end
   end

   // The pipeline moves as one; it only freezes once the skid register is occupied.
   assign en        = !skid_v_ff;
   assign req_stall = skid_v_ff;

   function automatic dv_type dv_step(input dv_type d, input logic [31:0] a);
      dv_type r;
      r     = d;
      r.tau = div_step(d.tau, {1'b0, a});
      r.tc  = div_step(d.tc, {1'b0, d.vpk});
      r.cof = div_step(d.cof, {a, 1'b0});
      return r;
   endfunction

   // Front stages.
   always_comb begin
      f_in[0]      = '0;
      f_in[0].item.q0 = req_word.start_pos;
      f_in[0].item.q1 = req_word.end_pos;
      f_in[0].item.t  = req_word.sample_time;
      f_in[0].d    = {req_word.end_pos[31], req_word.end_pos}
                     - {req_word.start_pos[31], req_word.start_pos};

      f_in[1]          = f_ff[0];
      f_in[1].item.neg = f_ff[0].d[32];
      f_in[1].item.nz  = |f_ff[0].d;
      f_in[1].item.mag = f_ff[0].d[32] ? (33'd0 - f_ff[0].d) : f_ff[0].d;

      // The product of a 33-bit distance and a 32-bit limit stays below 2^64.
      f_in[2]     = f_ff[1];
      f_in[2].pda = {31'd0, f_ff[1].item.mag} * {32'd0, alim};
      f_in[2].vv2 = vlim * vlim;

      f_in[3]       = f_ff[2];
      f_in[3].limit = f_ff[2].pda > f_ff[2].vv2;
   end

   // Square root of distance times acceleration, one root bit per stage.
   always_comb begin
      sq_type init;
      init       = '0;
      init.item  = f_ff[FR_STAGES-1].item;
      init.limit = f_ff[FR_STAGES-1].limit;
      init.xr    = f_ff[FR_STAGES-1].pda;
      sq_in[0]   = sqrt_step(init);
      for (int k = 1; k < SQ_STAGES; k++) begin
         sq_in[k] = sqrt_step(sq_ff[k-1]);
      end
   end

   // Peak velocity and the cruise offset numerator vpk*vpk + a.
   always_comb begin
      m_in[0]      = '0;
      m_in[0].item = sq_ff[SQ_STAGES-1].item;
      m_in[0].vpk  = sq_ff[SQ_STAGES-1].limit ? vlim : sq_ff[SQ_STAGES-1].root;

      m_in[1]     = m_ff[0];
      m_in[1].vsq = m_ff[0].vpk * m_ff[0].vpk;

      m_in[2]     = m_ff[1];
      m_in[2].num = m_ff[1].vsq + {32'd0, alim};
   end

   // Three dividers side by side, one quotient bit per stage.
   always_comb begin
      dv_type init;
      init        = '0;
      init.item   = m_ff[MD_STAGES-1].item;
      init.vpk    = m_ff[MD_STAGES-1].vpk;
      init.tau.nq = {16'd0, m_ff[MD_STAGES-1].vpk, 16'd0};
      init.tc.nq  = {15'd0, m_ff[MD_STAGES-1].item.mag, 16'd0};
      init.cof.nq = m_ff[MD_STAGES-1].num;
      dv_in[0]    = dv_step(init, alim);
      for (int k = 1; k < DIV_STAGES; k++) begin
         dv_in[k] = dv_step(dv_ff[k-1], alim);
      end
   end

   // Segment choice, the two product chains and the signed result.
   always_comb begin
      logic [49:0]        phi_full;
      logic [63:0]        p_rnd;
      logic [49:0]        pb_full;
      logic [47:0]        pc_full;
      logic [63:0]        p2_rnd;
      logic [47:0]        vmag;
      logic signed [65:0] velx;
      logic signed [65:0] accx;
      logic               aneg;
      logic signed [65:0] posx;

      e_in[0]      = '0;
      e_in[0].item = dv_ff[DIV_STAGES-1].item;
      e_in[0].vpk  = dv_ff[DIV_STAGES-1].vpk;
      e_in[0].tau  = dv_ff[DIV_STAGES-1].tau.nq[47:0];
      e_in[0].tc   = (dv_ff[DIV_STAGES-1].vpk == 32'd0) ? 49'd0
                                                          : dv_ff[DIV_STAGES-1].tc.nq[48:0];
      e_in[0].cof  = dv_ff[DIV_STAGES-1].cof.nq[62:0];
      e_in[0].total = {2'b00, dv_ff[DIV_STAGES-1].tau.nq[47:0]}
                      + {1'b0, ((dv_ff[DIV_STAGES-1].vpk == 32'd0) ? 49'd0
                                : dv_ff[DIV_STAGES-1].tc.nq[48:0])};
      e_in[0].ut   = {19'd0, dv_ff[DIV_STAGES-1].item.t[30:0]};
      e_in[0].tneg = dv_ff[DIV_STAGES-1].item.t[31];

      e_in[1]        = e_ff[0];
      e_in[1].le_tau = !e_ff[0].tneg && (e_ff[0].ut <= {2'b00, e_ff[0].tau});
      e_in[1].le_tc  = !e_ff[0].tneg && (e_ff[0].ut <= {1'b0, e_ff[0].tc});
      e_in[1].le_tot = !e_ff[0].tneg && (e_ff[0].ut <= e_ff[0].total);
      e_in[1].u      = e_ff[0].total - e_ff[0].ut;

      e_in[2] = e_ff[1];
      if (e_ff[1].le_tau) begin
         e_in[2].seg = SEG_ACCEL;
      end else if (e_ff[1].le_tc) begin
         e_in[2].seg = SEG_CRUISE;
      end else if (e_ff[1].le_tot) begin
         e_in[2].seg = SEG_DECEL;
      end else begin
         e_in[2].seg = SEG_OUTSIDE;
      end
      case (e_in[2].seg)
         SEG_ACCEL, SEG_CRUISE: begin
            e_in[2].w = e_ff[1].ut;
         end
         SEG_DECEL: begin
            e_in[2].w = e_ff[1].u;
         end
         default: begin
            e_in[2].w = 50'd0;
         end
      endcase
      e_in[2].m = (e_in[2].seg == SEG_CRUISE) ? e_ff[1].vpk : alim;

      // First product, kept modulo 2^64 as the profile arithmetic defines it.
      e_in[3]     = e_ff[2];
      e_in[3].plo = e_ff[2].m * e_ff[2].w[31:0];
      phi_full    = e_ff[2].m * e_ff[2].w[49:32];
      e_in[3].phi = phi_full[31:0];

      e_in[4]      = e_ff[3];
      e_in[4].prod = e_ff[3].plo + {e_ff[3].phi, 32'd0};

      e_in[5]    = e_ff[4];
      p_rnd      = e_ff[4].prod + 64'h8000;
      e_in[5].vv = p_rnd[63:16];

      // Second product vv*w, again modulo 2^64; cruise offset vt - c alongside.
      e_in[6]      = e_ff[5];
      e_in[6].pa   = e_ff[5].vv[31:0] * e_ff[5].w[31:0];
      pb_full      = e_ff[5].vv[31:0] * e_ff[5].w[49:32];
      pc_full      = e_ff[5].vv[47:32] * e_ff[5].w[31:0];
      e_in[6].pb   = pb_full[31:0];
      e_in[6].pc   = pc_full[31:0];
      e_in[6].off1 = {16'd0, e_ff[5].vv} - {1'b0, e_ff[5].cof};

      e_in[7]     = e_ff[6];
      e_in[7].pbc = e_ff[6].pb + e_ff[6].pc;

      e_in[8]       = e_ff[7];
      e_in[8].prod2 = e_ff[7].pa + {e_ff[7].pbc, 32'd0};

      e_in[9]     = e_ff[8];
      p2_rnd      = e_ff[8].prod2 + 64'h10000;
      e_in[9].off = (e_ff[8].seg == SEG_CRUISE) ? e_ff[8].off1 : {17'd0, p2_rnd[63:17]};

      // Signs: deceleration measures back from the end position.
      e_in[10] = e_ff[9];
      aneg     = (e_ff[9].seg == SEG_DECEL) ? !e_ff[9].item.neg : e_ff[9].item.neg;
      if (!e_ff[9].item.nz) begin
         e_in[10].term = 64'd0;
      end else if (aneg) begin
         e_in[10].term = 64'd0 - e_ff[9].off;
      end else begin
         e_in[10].term = e_ff[9].off;
      end
      e_in[10].base = (e_ff[9].seg == SEG_DECEL) ? e_ff[9].item.q1 : e_ff[9].item.q0;
      vmag = (e_ff[9].seg == SEG_CRUISE) ? {16'd0, e_ff[9].vpk} : e_ff[9].vv;
      velx = $signed({18'd0, vmag});
      if (!e_ff[9].item.nz) begin
         velx = '0;
      end else if (e_ff[9].item.neg) begin
         velx = -velx;
      end
      accx = $signed({34'd0, alim});
      if (!e_ff[9].item.nz || (e_ff[9].seg == SEG_CRUISE)) begin
         accx = '0;
      end else if (aneg) begin
         accx = -accx;
      end
      e_in[10].vel = sat32(velx);
      e_in[10].acc = sat32(accx);
      if (e_ff[9].seg == SEG_OUTSIDE) begin
         e_in[10].vel = 32'd0;
         e_in[10].acc = 32'd0;
      end

      e_in[11]     = e_ff[10];
      posx         = $signed({{2{e_ff[10].term[63]}}, e_ff[10].term})
                     + $signed({{34{e_ff[10].base[31]}}, e_ff[10].base});
      e_in[11].pos = (e_ff[10].seg == SEG_OUTSIDE) ? 32'd0 : sat32(posx);
   end

   always_comb begin
      pipe_word.position = $signed(e_ff[EV_STAGES-1].pos);
      pipe_word.velocity = $signed(e_ff[EV_STAGES-1].vel);
      pipe_word.accel    = $signed(e_ff[EV_STAGES-1].acc);
      pipe_word.segment  = e_ff[EV_STAGES-1].seg;
   end

   // Pipeline registers: payload without reset, valid bits with reset.
   always_ff @(posedge clock) begin
      if (en) begin
         f_ff  <= f_in;
         sq_ff <= sq_in;
         m_ff  <= m_in;
         dv_ff <= dv_in;
         e_ff  <= e_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[PIPE_STAGES-2:0], req_valid};
      end
   end

   // Output register plus a skid register.
   assign pipe_push = en && vld_ff[PIPE_STAGES-1];
   assign rsp_pop   = rsp_v_ff && !rsp_stall;
   assign rsp_valid = rsp_v_ff;
   assign rsp_word  = rsp_d_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (skid_v_ff) begin
         if (rsp_pop) begin
            skid_v_ff <= 1'b0;
         end
      end else if (pipe_push) begin
         if (!rsp_v_ff || rsp_pop) begin
            rsp_v_ff <= 1'b1;
         end else begin
            skid_v_ff <= 1'b1;
         end
      end else if (rsp_pop) begin
         rsp_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_v_ff) begin
         if (rsp_pop) begin
            rsp_d_ff <= skid_d_ff;
         end
      end else if (pipe_push) begin
         if (!rsp_v_ff || rsp_pop) begin
            rsp_d_ff <= pipe_word;
         end else begin
            skid_d_ff <= pipe_word;
         end
      end
   end

   `TMPE_ASSERT_ALWAYS(a_skid_needs_rsp, !skid_v_ff || rsp_v_ff)
   `TMPE_ASSERT_NEXT(a_result_caught, pipe_push && rsp_v_ff && rsp_stall, skid_v_ff)
   `TMPE_ASSERT_NEXT(a_frozen_pipe, !en, $stable(vld_ff))
   `TMPE_ASSERT_SAME(a_outside_zero, rsp_valid && (rsp_word.segment == SEG_OUTSIDE),
      (rsp_word.position == 32'sd0) && (rsp_word.velocity == 32'sd0) && (rsp_word.accel == 32'sd0))
   `TMPE_ASSERT_SAME(a_cruise_no_accel, rsp_valid && (rsp_word.segment == SEG_CRUISE),
      rsp_word.accel == 32'sd0)

endmodule

`default_nettype wire

### tb/sv/trapezoid_motion_profile_eval_checker.sv
// Checker for the trapezoid profile evaluator: watches the register port and both
// channels, predicts every response word and compares it. Depends on tmpe_pkg.
`timescale 1ns / 1ps

module trapezoid_motion_profile_eval_checker
   import tmpe_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_stall,
   input  req_word_type req_word,
   input  logic         rsp_valid,
   input  logic         rsp_stall,
   input  rsp_word_type rsp_word,
   input  logic         psel,
   input  logic         penable,
   input  logic         pwrite,
   input  logic [2:0]   paddr,
   input  logic [31:0]  pwdata,
   input  logic         pready,
   output int           fail_count,
   output int           words_pending
);

   logic [31:0]  vel_limit;
   logic [31:0]  accel_mag;
   rsp_word_type profile_queue[$];

   function automatic longint unsigned floor_root(input longint unsigned x);
      longint unsigned r;
      longint unsigned trial;
      r = 0;
      for (int i = 31; i >= 0; i--) begin
         trial = r | (64'd1 << i);
         if (trial * trial <= x) begin
            r = trial;
         end
      end
      return r;
   endfunction

   function automatic logic [31:0] clamp32(input longint v);
      if (v > 64'sd2147483647) begin
         return 32'h7fff_ffff;
      end else if (v < -64'sd2147483648) begin
         return 32'h8000_0000;
      end
      return v[31:0];
   endfunction

   // Profile sample at the requested time, in the 64-bit wrapping arithmetic
   // that the fixed point definition uses.
   function automatic rsp_word_type profile_sample(input req_word_type w);
      rsp_word_type    r;
      longint          q0, q1, t, d, s, pos, vel, acc, vt, c;
      longint unsigned move_len, v, a, vpk, tau, tc, total, ut, vv, off;
      q0 = longint'(w.start_pos);
      q1 = longint'(w.end_pos);
      t = longint'(w.sample_time);
      d = q1 - q0;
      s = (d > 0) ? 1 : ((d < 0) ? -1 : 0);
      move_len = (d < 0) ? -d : d;
      v = (vel_limit == 0) ? 1 : vel_limit;
      a = (accel_mag == 0) ? 1 : accel_mag;
      pos = 0;
      vel = 0;
      acc = 0;
      r.segment = SEG_OUTSIDE;
      if (move_len * a > v * v) begin
         vpk = v;
      end else begin
         vpk = floor_root(move_len * a);
      end
      tau = (vpk << 16) / a;
      tc = (vpk != 0) ? (move_len << 16) / vpk : 0;
      total = tc + tau;
      ut = t;
      if (t >= 0 && ut <= tau) begin
         vv = (a * ut + 64'h8000) >> 16;
         off = (vv * ut + 64'h10000) >> 17;
         pos = q0 + s * longint'(off);
         vel = s * longint'(vv);
         acc = s * longint'(a);
         r.segment = SEG_ACCEL;
      end else if (t >= 0 && ut <= tc) begin
         vt = longint'((vpk * ut + 64'h8000) >> 16);
         c = longint'((vpk * vpk + a) / (2 * a));
         pos = q0 + s * (vt - c);
         vel = s * longint'(vpk);
         r.segment = SEG_CRUISE;
      end else if (t >= 0 && ut <= total) begin
         ut = total - ut;
         vv = (a * ut + 64'h8000) >> 16;
         off = (vv * ut + 64'h10000) >> 17;
         pos = q1 - s * longint'(off);
         vel = s * longint'(vv);
         acc = -s * longint'(a);
         r.segment = SEG_DECEL;
      end
      r.position = clamp32(pos);
      r.velocity = clamp32(vel);
      r.accel = clamp32(acc);
      return r;
   endfunction

   assign words_pending = profile_queue.size();

   always @(posedge clock) begin
      rsp_word_type want;
      if (reset) begin
         vel_limit <= CFG_RESET_VALUE;
         accel_mag <= CFG_RESET_VALUE;
         profile_queue.delete();
         fail_count <= 0;
      end else begin
         if (psel && penable && pwrite && pready) begin
            if (paddr[2] == REG_MAX_ACCEL) begin
               accel_mag <= pwdata;
            end else begin
               vel_limit <= pwdata;
            end
         end
         if (req_valid && !req_stall) begin
            profile_queue.insert(profile_queue.size(), profile_sample(req_word));
         end
         if (rsp_valid && !rsp_stall) begin
            if (profile_queue.size() == 0) begin
               $error("response word with no request waiting");
               fail_count <= fail_count + 1;
            end else begin
               want = profile_queue.pop_front();
               if (want !== rsp_word) begin
                  fail_count <= fail_count + 1;
               end
               if (want.position !== rsp_word.position) begin
                  $error("position: expected %0d, got %0d", want.position, rsp_word.position);
               end
               if (want.velocity !== rsp_word.velocity) begin
                  $error("velocity: expected %0d, got %0d", want.velocity, rsp_word.velocity);
               end
               if (want.accel !== rsp_word.accel) begin
                  $error("accel: expected %0d, got %0d", want.accel, rsp_word.accel);
               end
               if (want.segment !== rsp_word.segment) begin
                  $error("segment: expected %0d, got %0d", want.segment, rsp_word.segment);
               end
            end
         end
      end
   end

endmodule

### tb/sv/trapezoid_motion_profile_eval_test.sv
// Top of the trapezoid profile evaluator test: clock, reset, register writes,
// request stimulus and response stalls. Depends on tmpe_pkg and the checker module.
`timescale 1ns / 1ps

module trapezoid_motion_profile_eval_test;
   import tmpe_pkg::*;

   localparam int DRAIN_CYCLES = PIPE_STAGES + 40;
   localparam int STALL_LIMIT  = 5000;

   logic         clock = 1'b0;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   req_word_type req_word;
   logic         rsp_valid;
   logic         rsp_stall;
   rsp_word_type rsp_word;
   logic         psel;
   logic         penable;
   logic         pwrite;
   logic [2:0]   paddr;
   logic [31:0]  pwdata;
   logic [31:0]  prdata;
   logic         pready;
   int           fail_count;
   int           words_pending;

   // The stimulus keeps its own copy of the register values, used only to aim
   // sample times into the interesting part of each move.
   logic [31:0]  cur_vel;
   logic [31:0]  cur_acc;
   // In the final phase neither side idles.
   bit           quiet;
   // Set once by the stimulus to make the receiver hold off for a long stretch.
   bit           hold_request;
   int           idle_cycles;

   always #5 clock = ~clock;

   trapezoid_motion_profile_eval dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_word(rsp_word),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   trapezoid_motion_profile_eval_checker checker_inst (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_word(rsp_word),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .pready(pready),
      .fail_count(fail_count), .words_pending(words_pending)
   );

   // Watchdog: any long run of cycles in which no word moves on either channel
   // means the block has hung.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("trapezoid_motion_profile_eval_test NOT OK");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Receiver: random stall bursts, one long hold-off when asked, none at the end.
   initial begin
      rsp_stall <= 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 0;
            rsp_stall <= 1'b1;
            repeat (400) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (!quiet && $urandom_range(0, 9) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 18)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Register write: a setup phase, then an access phase.
   task automatic csr_write(input logic sel, input logic [31:0] value);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {sel, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      if (sel == REG_MAX_ACCEL) begin
         cur_acc = value;
      end else begin
         cur_vel = value;
      end
   endtask

   // Offer one word and hold it until the block takes it. Valid stays high
   // between back-to-back words, and only drops for an idle burst.
   task automatic offer_word(input req_word_type w);
      if (!quiet && $urandom_range(0, 9) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (req_stall);
   endtask

   // The task waits for a clock edge first so that the checker has counted the last word taken.
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (words_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // A random move with a sample time spread over the whole profile and a bit
   // beyond both ends. D/V + V/A bounds the move time for both profile shapes.
   function automatic req_word_type random_move();
      req_word_type    w;
      longint unsigned move_len, v, a, span;
      int              kind;
      kind = $urandom_range(0, 9);
      w.start_pos = $urandom;
      if (kind == 0) begin
         w.end_pos = $urandom;
         w.sample_time = $urandom;
         return w;
      end
      w.start_pos = (kind < 5) ? $signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000
                               : $urandom;
      w.end_pos = (kind == 9) ? w.start_pos
                : w.start_pos + ($signed($urandom_range(0, 32'h01ff_ffff)) - 32'sh0100_0000);
      v = (cur_vel == 0) ? 1 : cur_vel;
      a = (cur_acc == 0) ? 1 : cur_acc;
      move_len = (w.end_pos > w.start_pos) ? longint'(w.end_pos) - longint'(w.start_pos)
                                           : longint'(w.start_pos) - longint'(w.end_pos);
      span = (move_len << 16) / v + (v << 16) / a;
      span = span + span / 8 + 2;
      if (span > 64'h7fff_fff0) begin
         span = 64'h7fff_fff0;
      end
      w.sample_time = $signed($urandom_range(0, span[30:0])) - 32'sd3;
      return w;
   endfunction

   initial begin
      req_word_type w;
      logic [31:0]  vel_set[8];
      logic [31:0]  acc_set[8];
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_word <= '0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      cur_vel = CFG_RESET_VALUE;
      cur_acc = CFG_RESET_VALUE;
      quiet = 0;
      hold_request = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed words at the reset setting (1.0 and 1.0).
      offer_word('{32'sd0, 32'sd0, 32'sd0});            // zero distance at time zero
      offer_word('{32'sd0, 32'sd0, 32'sd1});            // zero distance, later time
      offer_word('{32'sd0, 32'sh0001_0000, -32'sd1});   // before the move
      offer_word('{32'sd0, 32'sh0001_0000, 32'sd0});
      offer_word('{32'sd0, 32'sh0001_0000, 32'sh0001_0000});
      offer_word('{32'sd0, 32'sh0001_0000, 32'sh0001_8000});
      offer_word('{32'sd0, 32'sh0001_0000, 32'sh0002_0000}); // end of move
      offer_word('{32'sd0, 32'sh0001_0000, 32'sh0002_0001}); // just past the end
      offer_word('{32'sh0005_0000, 32'sd0, 32'sh0000_8000}); // negative direction
      offer_word('{32'sh0005_0000, 32'sd0, 32'sh0003_0000}); // cruise, negative
      offer_word('{32'sd0, 32'sh0005_0000, 32'sh0004_0000}); // cruise, positive
      offer_word('{32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff});
      offer_word('{32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff});
      offer_word('{32'sh7fff_ffff, 32'sh8000_0000, 32'sh8000_0000});
      offer_word('{32'sh8000_0000, 32'sh7fff_ffff, 32'sh4000_0000});
      offer_word('{32'sd5, 32'sd7, 32'sd65536});          // tiny triangular move
      wait_idle();

      // Register settings: extremes first, including zero read as one, then random, then the reset values.
      vel_set = '{32'hffff_ffff, 32'd0, 32'd1, 32'hffff_ffff, 32'h0004_0000,
                  $urandom, $urandom_range(1, 32'h0010_0000), CFG_RESET_VALUE};
      acc_set = '{32'hffff_ffff, 32'd0, 32'hffff_ffff, 32'd1, 32'h0002_0000,
                  $urandom, $urandom_range(1, 32'h0010_0000), CFG_RESET_VALUE};
      for (int p = 0; p < 8; p++) begin
         csr_write(REG_MAX_VELOCITY, vel_set[p]);
         csr_write(REG_MAX_ACCEL, acc_set[p]);
         quiet = (p == 7);
         for (int i = 0; i < 110; i++) begin
            // Long receiver hold-off while words keep coming, to fill the pipeline.
            if (p == 4 && i == 10) begin
               hold_request = 1;
            end
            w = random_move();
            offer_word(w);
         end
         wait_idle();
      end

      if (fail_count == 0 && words_pending == 0) begin
         $display("trapezoid_motion_profile_eval_test OK");
      end else begin
         $display("trapezoid_motion_profile_eval_test NOT OK");
      end
      $finish;
   end

endmodule
